>>> design/lpf_pkg.sv
`timescale 1ns / 1ps
// Package for the largest prime factor block: widths, packing constants and
// the request/response structs between the controller and the serial divider.
// No dependencies.
package lpf_pkg;

    localparam int VALUE_BITS = 31;
    localparam int OUT_BITS   = 32;
    localparam int IN_TDATA_W = ((VALUE_BITS + 7) / 8) * 8;
    localparam int CNT_W      = $clog2(VALUE_BITS);

    typedef logic [VALUE_BITS-1:0] value_t;

    typedef struct packed {
        logic   start;
        value_t dividend;
        value_t divisor;
    } div_req_t;

    typedef struct packed {
        logic   done;
        value_t quotient;
        value_t remainder;
    } div_rsp_t;

endpackage

>>> design/largest_prime_factor_top.sv
`timescale 1ns / 1ps
// Sequencing: factors of two are stripped first, then each odd trial division runs on the
// bit-serial divider (one quotient bit per cycle); zero and one go straight to the result.
// A 31-bit prime needs about 23000 divisions.
// Throughput: one item at a time; the next is taken in the cycle after the result is
// registered, even while that result beat still waits.
// Reset (aresetn low, synchronous) clears all handshake and sequencing state.
module largest_prime_factor_top
    import lpf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,   // [VALUE_BITS-1:0] number, rest zero
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_BITS-1:0]   m_tdata    // [31:0] largest_factor
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_STRIP  = 3'd1;
    localparam logic [2:0] ST_LAUNCH = 3'd2;
    localparam logic [2:0] ST_WAIT   = 3'd3;
    localparam logic [2:0] ST_FINAL  = 3'd4;

    logic [2:0]            state_reg, state_next;
    value_t                n_reg, n_next;
    value_t                d_reg, d_next;
    value_t                best_reg, best_next;
    logic                  inner_reg, inner_next;
    logic                  mvalid_reg, mvalid_next;
    logic [OUT_BITS-1:0]   mdata_reg, mdata_next;
    logic [VALUE_BITS+OUT_BITS-1:0] ext;
    value_t                in_value;
    value_t                pick;
    div_req_t              req;
    div_rsp_t              rsp;

    assign in_value = s_tdata[VALUE_BITS-1:0];
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

    assign req.start    = (state_reg == ST_LAUNCH);
    assign req.dividend = n_reg;
    assign req.divisor  = d_reg;

    // A remainder above two is the answer; otherwise the last divisor found.
    assign pick = (n_reg > VALUE_BITS'(2)) ? n_reg : best_reg;
    assign ext  = {{OUT_BITS{1'b0}}, pick};

    always_comb begin
        state_next  = state_reg;
        n_next      = n_reg;
        d_next      = d_reg;
        best_next   = best_reg;
        inner_next  = inner_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    n_next    = in_value;
                    best_next = '0;
                    if (in_value < VALUE_BITS'(2)) begin
                        state_next = ST_FINAL;
                    end else begin
                        state_next = ST_STRIP;
                    end
                end
            end
            ST_STRIP: begin
                if (!n_reg[0]) begin
                    best_next = VALUE_BITS'(2);
                    n_next    = n_reg >> 1;
                end else begin
                    d_next     = VALUE_BITS'(3);
                    inner_next = 1'b0;
                    state_next = ST_LAUNCH;
                end
            end
            ST_LAUNCH: begin
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (rsp.done) begin
                    // The bound test d*d <= n is d <= n/d; it is made only
                    // when a new divisor is tried, not between repeats.
                    if (!inner_reg && (d_reg > rsp.quotient)) begin
                        state_next = ST_FINAL;
                    end else if (rsp.remainder == '0) begin
                        best_next  = d_reg;
                        n_next     = rsp.quotient;
                        inner_next = 1'b1;
                        state_next = ST_LAUNCH;
                    end else begin
                        d_next     = d_reg + VALUE_BITS'(2);
                        inner_next = 1'b0;
                        state_next = ST_LAUNCH;
                    end
                end
            end
            ST_FINAL: begin
                if (!mvalid_reg || m_tready) begin
                    mvalid_next = 1'b1;
                    if (pick == '0) begin
                        mdata_next = '1;
                    end else begin
                        mdata_next = ext[OUT_BITS-1:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
            inner_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
            inner_reg  <= inner_next;
        end
        n_reg     <= n_next;
        d_reg     <= d_next;
        best_reg  <= best_next;
        mdata_reg <= mdata_next;
    end

    lpf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp)
    );

endmodule

>>> design/lpf_div.sv
`timescale 1ns / 1ps
// Restoring divider that produces one quotient bit per cycle.
// Depends on lpf_pkg for widths and the request/response structs.
module lpf_div
    import lpf_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    value_t                rem_reg, rem_next;
    value_t                quo_reg, quo_next;
    value_t                dvs_reg, dvs_next;
    logic [VALUE_BITS:0]   trial;
    logic [VALUE_BITS:0]   diff;

    // The dividend shifts out of the top of quo_reg while quotient bits
    // shift in at the bottom.
    assign trial = {rem_reg, quo_reg[VALUE_BITS-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            if (!diff[VALUE_BITS]) begin
                rem_next = diff[VALUE_BITS-1:0];
                quo_next = {quo_reg[VALUE_BITS-2:0], 1'b1};
            end else begin
                rem_next = trial[VALUE_BITS-1:0];
                quo_next = {quo_reg[VALUE_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(VALUE_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

>>> design/lpf_checker.sv
`timescale 1ns / 1ps
// Port-level checks for largest_prime_factor_top, attached by bind.
// Depends on lpf_pkg for the port widths.
module lpf_checker
    import lpf_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_BITS-1:0]   m_tdata
);

    // No result beat may be offered right after reset.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result beat holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // One item is in work at a time: after an input beat, the port closes.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second input taken while busy");

    // A prime factor is at least two; zero and one never appear.
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata != '0) && (m_tdata != OUT_BITS'(1)))
        else $error("result is not a prime factor or minus one");

endmodule

bind largest_prime_factor_top lpf_checker u_lpf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> bench/tb_largest_prime_factor_top.sv
`timescale 1ns / 1ps
// Self-checking bench for largest_prime_factor_top: it drives numbers on the input
// stream and checks each factor on the result stream against a trial-division predictor.
// Depends on lpf_pkg and the largest_prime_factor_top RTL.
module tb_largest_prime_factor_top;
    import lpf_pkg::*;

    localparam logic [OUT_BITS-1:0] NO_FACTOR  = '1;
    localparam int                  MAX_IDLE   = 11;
    localparam int                  HOLD_BEATS = 3000;
    localparam int                  MAX_SHOWN  = 10;

    typedef struct {
        value_t              number;
        logic [OUT_BITS-1:0] factor;
    } factor_entry_t;

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_TDATA_W-1:0] s_tdata  = '0;     // [30:0] number, [31] zero
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_BITS-1:0]   m_tdata;           // [31:0] largest_factor

    factor_entry_t expected_factors[$];
    int            fail_count = 0;
    bit            no_idle    = 1'b0;
    int            stall_left = 0;
    int            hold_left  = 0;

    largest_prime_factor_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Trial division at 64 bits, so the divisor bound never overflows.
    function automatic logic [OUT_BITS-1:0] largest_factor_of(input value_t number);
        longint unsigned rest;
        longint unsigned divisor;
        longint unsigned best;
        bit              found;
        rest  = number;
        best  = 0;
        found = 1'b0;
        if (rest < 2) return NO_FACTOR;
        while ((rest & 1) == 0) begin
            best  = 2;
            found = 1'b1;
            rest  = rest >> 1;
        end
        for (divisor = 3; divisor <= rest / divisor; divisor += 2) begin
            while (rest % divisor == 0) begin
                best  = divisor;
                found = 1'b1;
                rest  = rest / divisor;
            end
        end
        if (rest > 2) begin
            best  = rest;
            found = 1'b1;
        end
        if (!found) return NO_FACTOR;
        return best[OUT_BITS-1:0];
    endfunction

    // Numbers are built so that trial division stays short: zero or one, shifted small values,
    // products of two small odd values, or products of small primes.
    function automatic value_t random_number();
        longint unsigned value;
        longint unsigned prime;
        int              width;
        int              pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            value = $urandom_range(0, 1);
        end else if (pick <= 6) begin
            value = (pick <= 3) ? $urandom_range(2, 4095) : $urandom_range(2, 65535);
            width = $clog2(value + 1);
            value = value << $urandom_range(0, VALUE_BITS - width);
        end else if (pick <= 8) begin
            value = longint'($urandom_range(1, 511) * 2 + 1) * ($urandom_range(1, 511) * 2 + 1);
            width = $clog2(value + 1);
            value = value << $urandom_range(0, VALUE_BITS - width);
        end else begin
            value = 1;
            repeat (40) begin
                case ($urandom_range(0, 5))
                    0:       prime = 2;
                    1:       prime = 3;
                    2:       prime = 5;
                    3:       prime = 7;
                    4:       prime = 11;
                    default: prime = 13;
                endcase
                if (value * prime < (64'd1 << VALUE_BITS)) value = value * prime;
            end
        end
        return value_t'(value);
    endfunction

    // Called and returning at a falling edge; valid stays high when the next gap is zero.
    task automatic send_number(input value_t number);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'(number);
        do @(posedge aclk); while (!s_tready);
        expected_factors.push_back('{number, largest_factor_of(number)});
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_factors.size() != 0) @(negedge aclk);
    endtask

    task automatic note_failure(input value_t number, input logic [OUT_BITS-1:0] want,
                                input logic [OUT_BITS-1:0] got, input bit orphan);
        if (fail_count < MAX_SHOWN) begin
            if (orphan)
                $display("unexpected result beat: got %0d", $signed(got));
            else
                $display("mismatch for number %0d: expected %0d, got %0d",
                         number, $signed(want), $signed(got));
        end
        fail_count++;
    endtask

    // Result side: compare every accepted beat with the oldest expectation.
    always @(posedge aclk) begin : check_results
        factor_entry_t head;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_factors.size() == 0) begin
                note_failure('0, '0, m_tdata, 1'b1);
            end else begin
                head = expected_factors.pop_front();
                if (m_tdata !== head.factor) note_failure(head.number, head.factor, m_tdata, 1'b0);
            end
            stall_left = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
        end
    end

    // Result side ready: a long hold takes priority over the per-beat stall.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic test_special_values();
        send_number(31'd0);
        send_number(31'd1);
        send_number(31'd2);
        send_number(31'd3);
        send_number(31'd4);
        send_number(31'd15);
        send_number(31'h4000_0000);
        send_number(31'd1162261467);   // three to the nineteenth
        send_number(31'd223092870);    // product of the primes up to 23
        wait_drained();
    endtask

    task automatic test_divisor_bound();
        // Squares and twin products sit right on the divisor-squared boundary; 92674 is twice a prime.
        send_number(31'd9);
        send_number(31'd25);
        send_number(31'd49);
        send_number(31'd961);
        send_number(31'd1042441);
        send_number(31'd35);
        send_number(31'd143);
        send_number(31'd92674);
        wait_drained();
    endtask

    task automatic test_largest_values();
        send_number(31'h7FFF_FFFE);
        send_number(31'h7FFF_FFFF);    // prime, the slowest input of all
        wait_drained();
    endtask

    task automatic test_random_mixed();
        repeat (57) send_number(random_number());
        wait_drained();
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        repeat (14) send_number(random_number());
        wait_drained();
        no_idle = 1'b0;
    endtask

    task automatic test_output_hold();
        @(posedge aclk);
        hold_left = HOLD_BEATS;
        @(negedge aclk);
        repeat (10) send_number(value_t'($urandom_range(2, 255)));
        wait_drained();
    endtask

    initial begin
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_special_values();
        test_divisor_bound();
        test_largest_values();
        test_output_hold();
        test_random_mixed();
        test_back_to_back();
        repeat (100) @(posedge aclk);
        if (fail_count == 0 && expected_factors.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #120_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

>>> sim.f
design/lpf_pkg.sv
design/lpf_div.sv
design/largest_prime_factor_top.sv
design/lpf_checker.sv
bench/tb_largest_prime_factor_top.sv
